// File: design/utf8_to_utf16_transcoder_unit_macros.svh
// Assertion macros shared by the transcoder RTL.
`ifndef UTF8_TO_UTF16_TRANSCODER_UNIT_MACROS_SVH
`define UTF8_TO_UTF16_TRANSCODER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset
`define UTU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked out of reset
`define UTU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define UTU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define UTU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: design/utu_pkg.sv
package utu_pkg;

    // Unit limit and counter widths
    localparam int MaxUnits   = 64;
    localparam int UnitW      = 7;

    // Job queue between front and back
    localparam int QueueDepth = 4;
    localparam int QPtrW      = 2;
    localparam int QCntW      = 3;

    // Operation codes
    localparam logic OpData = 1'b0;
    localparam logic OpEnd  = 1'b1;

    // Code unit constants
    localparam logic [15:0] RepChar  = 16'hFFFD;
    localparam logic [15:0] SurHi    = 16'hD800;
    localparam logic [15:0] SurLo    = 16'hDC00;
    localparam logic [20:0] SuppBase = 21'h10000;

    // Up to two units caused by one item; positions are pos and pos + 1,
    // term marks the last unit as the closing zero
    typedef struct packed {
        logic [1:0]       cnt;
        logic [15:0]      unit0;
        logic [15:0]      unit1;
        logic [UnitW-1:0] pos;
        logic             term;
    } t_job;

endpackage

// File: design/utf8_to_utf16_transcoder_unit.sv
// Channel  | Handshake          | Payload
// input    | i_push / o_full    | i_operation, i_byte_in
// result   | o_empty / i_pop    | o_code_unit, o_unit_position, o_is_terminator, o_run_last
// config   | i_max_units_we     | i_max_units
//
// One item is accepted per cycle while the four-entry job queue has room.
// Results leave one unit per cycle while i_pop is high; an item with two units holds the result
// port for both of its units, so the output port sets the sustained rate.
// A result passes through the job queue and then the back-end job register before it shows
// on the result ports; it can be taken at the next edge.
// Reset is synchronous, active low; the unit limit comes out of reset at 64.
module utf8_to_utf16_transcoder_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    output logic                      o_full,
    input  logic                      i_operation,
    input  logic [7:0]                i_byte_in,
    output logic                      o_empty,
    input  logic                      i_pop,
    output logic [15:0]               o_code_unit,
    output logic [utu_pkg::UnitW-1:0] o_unit_position,
    output logic                      o_is_terminator,
    output logic                      o_run_last,
    input  logic                      i_max_units_we,
    input  logic [utu_pkg::UnitW-1:0] i_max_units
);
    import utu_pkg::*;

    logic accept;
    logic job_valid;
    t_job job_in;
    t_job job_out;
    logic q_nonempty;
    logic q_take;

    assign accept = i_push && !o_full;

    // Classification and string state
    utu_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_operation    (i_operation),
        .i_byte_in      (i_byte_in),
        .i_max_units_we (i_max_units_we),
        .i_max_units    (i_max_units),
        .o_job_valid    (job_valid),
        .o_job          (job_in)
    );

    // Job queue
    utu_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (job_valid),
        .i_job      (job_in),
        .i_pop      (q_take),
        .o_job      (job_out),
        .o_full     (o_full),
        .o_nonempty (q_nonempty)
    );

    // Unit output
    utu_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_job           (job_out),
        .i_job_avail     (q_nonempty),
        .o_job_take      (q_take),
        .i_pop           (i_pop),
        .o_empty         (o_empty),
        .o_code_unit     (o_code_unit),
        .o_unit_position (o_unit_position),
        .o_is_terminator (o_is_terminator),
        .o_run_last      (o_run_last)
    );

endmodule

// File: design/utu_front.sv
module utu_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_accept,
    input  logic                      i_operation,
    input  logic [7:0]                i_byte_in,
    input  logic                      i_max_units_we,
    input  logic [utu_pkg::UnitW-1:0] i_max_units,
    output logic                      o_job_valid,
    output utu_pkg::t_job             o_job
);
    import utu_pkg::*;

    typedef struct packed {
        logic [1:0]  cnt;
        logic [15:0] u0;
        logic [15:0] u1;
    } t_emit;

    logic [20:0]      r_pending,   n_pending;
    logic [1:0]       r_remaining, n_remaining;
    logic [UnitW-1:0] r_units,     n_units;
    logic [UnitW-1:0] r_max_units;
    logic [UnitW-1:0] lim;
    logic [UnitW-1:0] uw1;
    logic [20:0]      acc;
    t_emit            e1;
    logic             start;
    logic             sec_v;
    logic [15:0]      sec_u;
    logic             sec_t;

    // One character into zero, one or two units, given room left
    function automatic t_emit f_emit(input logic [20:0] cp, input logic [UnitW-1:0] uw,
                                     input logic [UnitW-1:0] lm);
        t_emit       e;
        logic [20:0] s;
        e = '0;
        s = cp - SuppBase;
        if (cp[20:16] == 5'd0) begin
            if (uw < lm) begin
                e.cnt = 2'd1;
                e.u0  = cp[15:0];
            end
        end else if (({1'b0, uw} + (UnitW+1)'(1)) < {1'b0, lm}) begin
            e.cnt = 2'd2;
            e.u0  = SurHi | {5'd0, s[20:10]};
            e.u1  = SurLo | {6'd0, s[9:0]};
        end
        return e;
    endfunction

    // Effective unit limit
    assign lim = (r_max_units == '0 || r_max_units > UnitW'(MaxUnits))
                 ? UnitW'(MaxUnits) : r_max_units;

    // Classify the item and work out the next state
    always_comb begin
        e1          = '0;
        start       = 1'b0;
        sec_v       = 1'b0;
        sec_u       = '0;
        sec_t       = 1'b0;
        n_pending   = r_pending;
        n_remaining = r_remaining;
        acc         = {r_pending[14:0], i_byte_in[5:0]};
        if (i_operation == OpEnd) begin
            // flush partial, then closing zero
            if (r_remaining != 2'd0) begin
                e1 = f_emit(r_pending, r_units, lim);
            end
            sec_v       = 1'b1;
            sec_t       = 1'b1;
            n_pending   = '0;
            n_remaining = 2'd0;
        end else if (r_remaining != 2'd0) begin
            if (i_byte_in[7:6] == 2'b10) begin
                n_remaining = r_remaining - 2'd1;
                if (r_remaining == 2'd1) begin
                    e1        = f_emit(acc, r_units, lim);
                    n_pending = '0;
                end else begin
                    n_pending = acc;
                end
            end else begin
                // broken sequence: partial out, byte starts anew
                e1          = f_emit(r_pending, r_units, lim);
                n_pending   = '0;
                n_remaining = 2'd0;
                start       = 1'b1;
            end
        end else begin
            start = 1'b1;
        end

        uw1 = r_units + {5'd0, e1.cnt};

        // Lead byte handling, skipped once the string is full
        if (start && uw1 < lim) begin
            if (i_byte_in[7] == 1'b0) begin
                sec_v = 1'b1;
                sec_u = {8'd0, i_byte_in};
            end else if (i_byte_in[7:5] == 3'b110) begin
                n_pending   = {16'd0, i_byte_in[4:0]};
                n_remaining = 2'd1;
            end else if (i_byte_in[7:4] == 4'b1110) begin
                n_pending   = {17'd0, i_byte_in[3:0]};
                n_remaining = 2'd2;
            end else if (i_byte_in[7:3] == 5'b11110) begin
                n_pending   = {18'd0, i_byte_in[2:0]};
                n_remaining = 2'd3;
            end else begin
                sec_v = 1'b1;
                sec_u = RepChar;
            end
        end

        n_units = (i_operation == OpEnd) ? '0 : uw1 + {6'd0, sec_v};
    end

    // Job for the back end
    always_comb begin
        o_job.cnt   = e1.cnt + {1'b0, sec_v};
        o_job.unit0 = (e1.cnt != 2'd0) ? e1.u0 : sec_u;
        o_job.unit1 = (e1.cnt == 2'd2) ? e1.u1 : sec_u;
        o_job.pos   = r_units;
        o_job.term  = sec_t;
    end
    assign o_job_valid = i_accept && (o_job.cnt != 2'd0);

    // String state and limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending   <= '0;
            r_remaining <= 2'd0;
            r_units     <= '0;
            r_max_units <= UnitW'(MaxUnits);
        end else begin
            if (i_accept) begin
                r_pending   <= n_pending;
                r_remaining <= n_remaining;
                r_units     <= n_units;
            end
            if (i_max_units_we) begin
                r_max_units <= i_max_units;
            end
        end
    end

endmodule

// File: design/utu_queue.sv
`include "utf8_to_utf16_transcoder_unit_macros.svh"

module utu_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  utu_pkg::t_job i_job,
    input  logic          i_pop,
    output utu_pkg::t_job o_job,
    output logic          o_full,
    output logic          o_nonempty
);
    import utu_pkg::*;

    t_job             r_mem [QueueDepth];
    logic [QPtrW-1:0] r_wr_ptr;
    logic [QPtrW-1:0] r_rd_ptr;
    logic [QCntW-1:0] r_count;

    assign o_full     = (r_count == QCntW'(QueueDepth));
    assign o_nonempty = (r_count != '0);
    assign o_job      = r_mem[r_rd_ptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPtrW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPtrW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCntW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - QCntW'(1);
            end
        end
    end

    `UTU_ASSERT_IMPL(a_no_push_full, i_clk, i_rst_n, o_full, !i_push)
    `UTU_ASSERT_IMPL(a_no_pop_empty, i_clk, i_rst_n, i_pop, o_nonempty)
    `UTU_ASSERT_NEXT(a_count_up, i_clk, i_rst_n, i_push && !i_pop, r_count == $past(r_count) + QCntW'(1))

endmodule

// File: design/utu_back.sv
module utu_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  utu_pkg::t_job             i_job,
    input  logic                      i_job_avail,
    output logic                      o_job_take,
    input  logic                      i_pop,
    output logic                      o_empty,
    output logic [15:0]               o_code_unit,
    output logic [utu_pkg::UnitW-1:0] o_unit_position,
    output logic                      o_is_terminator,
    output logic                      o_run_last
);
    import utu_pkg::*;

    t_job r_job;
    logic r_valid;
    logic r_idx;
    logic last;
    logic load;

    // Current unit is the last of its item
    assign last       = r_idx || (r_job.cnt == 2'd1);
    assign load       = !r_valid || (i_pop && last);
    assign o_job_take = load && i_job_avail;

    // Result ports
    assign o_empty         = !r_valid;
    assign o_code_unit     = r_idx ? r_job.unit1 : r_job.unit0;
    assign o_unit_position = r_job.pos + {6'd0, r_idx};
    assign o_is_terminator = last && r_job.term;
    assign o_run_last      = last;

    // Job payload
    always_ff @(posedge i_clk) begin
        if (o_job_take) begin
            r_job <= i_job;
        end
    end

    // Unit sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 1'b0;
        end else if (load) begin
            r_valid <= i_job_avail;
            r_idx   <= 1'b0;
        end else if (i_pop) begin
            r_idx <= 1'b1;
        end
    end

endmodule

// File: bench/utf8_to_utf16_transcoder_unit_checker.sv
`timescale 1ns / 100ps

// Watches the item and result channels of the transcoder, predicts every
// UTF-16 unit from the accepted items and compares the results in order.
module utf8_to_utf16_transcoder_unit_checker
    import utu_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic             i_full,
    input  logic             i_operation,
    input  logic [7:0]       i_byte_in,
    input  logic             i_empty,
    input  logic             i_pop,
    input  logic [15:0]      i_code_unit,
    input  logic [UnitW-1:0] i_unit_position,
    input  logic             i_is_terminator,
    input  logic             i_run_last,
    input  logic             i_max_units_we,
    input  logic [UnitW-1:0] i_max_units,
    output int               o_fail_count,
    output int               o_waiting,
    output int               o_items,
    output int               o_units,
    output int               o_strings
);

    typedef struct packed {
        logic [15:0]      code;
        logic [UnitW-1:0] pos;
        logic             term;
        logic             last;
    } unit_rec_t;

    unit_rec_t        units_due[$];   // expected units, oldest first
    unit_rec_t        item_units[$];  // units caused by the current item
    logic [20:0]      seq_value;      // bits gathered of an open sequence
    int               seq_left;       // continuation bytes still expected
    int               units_done;     // units written in this string
    logic [UnitW-1:0] limit_reg;
    int               fail_total;
    int               items_seen;
    int               units_seen;
    int               strings_seen;

    // Out-of-range limit falls back to the full size
    function automatic int unit_cap();
        if (limit_reg == 0 || limit_reg > MaxUnits) begin
            return MaxUnits;
        end
        return int'(limit_reg);
    endfunction

    task automatic add_unit(input logic [15:0] code, input logic term);
        unit_rec_t rec;
        rec.code = code;
        rec.pos  = units_done[UnitW-1:0];
        rec.term = term;
        rec.last = 1'b0;
        item_units.push_back(rec);
    endtask

    // One character: a single unit, or a surrogate pair when both slots fit
    task automatic put_char(input logic [20:0] cp);
        logic [20:0] offs;
        if (cp <= 21'h00FFFF) begin
            if (units_done < unit_cap()) begin
                add_unit(cp[15:0], 1'b0);
                units_done++;
            end
        end else if (units_done + 1 < unit_cap()) begin
            offs = cp - SuppBase;
            add_unit(SurHi | {5'd0, offs[20:10]}, 1'b0);
            units_done++;
            add_unit(SurLo | {6'd0, offs[9:0]}, 1'b0);
            units_done++;
        end
    endtask

    // Byte with no open sequence; ignored once the string is full
    task automatic open_char(input logic [7:0] b);
        if (units_done >= unit_cap()) begin
            return;
        end
        if (!b[7]) begin
            put_char({13'd0, b});
        end else if (b[7:5] == 3'b110) begin
            seq_value = {16'd0, b[4:0]};
            seq_left  = 1;
        end else if (b[7:4] == 4'b1110) begin
            seq_value = {17'd0, b[3:0]};
            seq_left  = 2;
        end else if (b[7:3] == 5'b11110) begin
            seq_value = {18'd0, b[2:0]};
            seq_left  = 3;
        end else begin
            put_char({5'd0, RepChar});
        end
    endtask

    task automatic flag(input string msg);
        fail_total++;
        if (fail_total <= 10) begin
            $display("%0t: %s", $realtime, msg);
        end
    endtask

    always @(posedge i_clk) begin : track
        logic [20:0] partial;
        unit_rec_t   want;
        if (!i_rst_n) begin
            units_due.delete();
            seq_value    = '0;
            seq_left     = 0;
            units_done   = 0;
            limit_reg    = UnitW'(MaxUnits);
            fail_total   = 0;
            items_seen   = 0;
            units_seen   = 0;
            strings_seen = 0;
        end else begin
            if (i_max_units_we) begin
                limit_reg = i_max_units;
            end

            // Predict the units of an accepted item
            if (i_push && !i_full) begin
                items_seen++;
                item_units.delete();
                if (i_operation == OpEnd) begin
                    // flush open sequence, then closing zero
                    if (seq_left != 0) begin
                        put_char(seq_value);
                    end
                    add_unit(16'h0000, 1'b1);
                    seq_value  = '0;
                    seq_left   = 0;
                    units_done = 0;
                end else if (seq_left != 0) begin
                    if (i_byte_in[7:6] == 2'b10) begin
                        seq_value = {seq_value[14:0], i_byte_in[5:0]};
                        seq_left--;
                        if (seq_left == 0) begin
                            put_char(seq_value);
                            seq_value = '0;
                        end
                    end else begin
                        // broken sequence: partial value, then a fresh start
                        partial   = seq_value;
                        seq_value = '0;
                        seq_left  = 0;
                        put_char(partial);
                        open_char(i_byte_in);
                    end
                end else begin
                    open_char(i_byte_in);
                end
                if (item_units.size() > 0) begin
                    item_units[item_units.size() - 1].last = 1'b1;
                end
                foreach (item_units[i]) begin
                    units_due.push_back(item_units[i]);
                end
            end

            // Compare an accepted result with the oldest expectation
            if (i_pop && !i_empty) begin
                units_seen++;
                if (units_due.size() == 0) begin
                    flag($sformatf("unexpected unit %h at position %0d term %b last %b",
                                   i_code_unit, i_unit_position, i_is_terminator,
                                   i_run_last));
                end else begin
                    want = units_due.pop_front();
                    if (want.term) begin
                        strings_seen++;
                    end
                    if (i_code_unit !== want.code || i_unit_position !== want.pos ||
                        i_is_terminator !== want.term || i_run_last !== want.last) begin
                        flag($sformatf({"unit mismatch: exp %h pos %0d term %b last %b, ",
                                        "got %h pos %0d term %b last %b"},
                                       want.code, want.pos, want.term, want.last,
                                       i_code_unit, i_unit_position, i_is_terminator,
                                       i_run_last));
                    end
                end
            end
        end
        o_fail_count <= fail_total;
        o_waiting    <= units_due.size();
        o_items      <= items_seen;
        o_units      <= units_seen;
        o_strings    <= strings_seen;
    end

endmodule

// File: bench/utf8_to_utf16_transcoder_unit_test.sv
`timescale 1ns / 100ps

module utf8_to_utf16_transcoder_unit_test;
    import utu_pkg::*;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_push;
    logic             o_full;
    logic             i_operation;
    logic [7:0]       i_byte_in;
    logic             o_empty;
    logic             i_pop;
    logic [15:0]      o_code_unit;
    logic [UnitW-1:0] o_unit_position;
    logic             o_is_terminator;
    logic             o_run_last;
    logic             i_max_units_we;
    logic [UnitW-1:0] i_max_units;

    int fail_count;
    int waiting;
    int items;
    int units;
    int strings;
    int sent;
    int settings_used;
    bit send_calm;
    bit pop_calm;

    // Unit limits per phase: extremes, tiny strings, out-of-range values
    logic [UnitW-1:0] phase_limits [10] = '{7'd64, 7'd1, 7'd2, 7'd3, 7'd0,
                                            7'd127, 7'd65, 7'd33, 7'd17, 7'd64};

    utf8_to_utf16_transcoder_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (i_push),
        .o_full          (o_full),
        .i_operation     (i_operation),
        .i_byte_in       (i_byte_in),
        .o_empty         (o_empty),
        .i_pop           (i_pop),
        .o_code_unit     (o_code_unit),
        .o_unit_position (o_unit_position),
        .o_is_terminator (o_is_terminator),
        .o_run_last      (o_run_last),
        .i_max_units_we  (i_max_units_we),
        .i_max_units     (i_max_units)
    );

    utf8_to_utf16_transcoder_unit_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (i_push),
        .i_full          (o_full),
        .i_operation     (i_operation),
        .i_byte_in       (i_byte_in),
        .i_empty         (o_empty),
        .i_pop           (i_pop),
        .i_code_unit     (o_code_unit),
        .i_unit_position (o_unit_position),
        .i_is_terminator (o_is_terminator),
        .i_run_last      (o_run_last),
        .i_max_units_we  (i_max_units_we),
        .i_max_units     (i_max_units),
        .o_fail_count    (fail_count),
        .o_waiting       (waiting),
        .o_items         (items),
        .o_units         (units),
        .o_strings       (strings)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 88) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Offer one item and hold it until accepted
    task automatic send_item(input logic op, input logic [7:0] b);
        int gap;
        gap = send_calm ? 0 : pick_gap();
        if (gap > 0) begin
            i_push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_push      <= 1'b1;
        i_operation <= op;
        i_byte_in   <= b;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
        sent++;
    endtask

    // UTF-8 encoding of cp in len bytes, only the first count bytes sent
    task automatic send_seq(input logic [20:0] cp, input int len, input int count);
        logic [7:0]  lead;
        logic [20:0] shifted;
        case (len)
            2:       lead = {3'b110, cp[10:6]};
            3:       lead = {4'b1110, cp[15:12]};
            default: lead = {5'b11110, cp[20:18]};
        endcase
        for (int i = 0; i < count; i++) begin
            if (i == 0) begin
                send_item(OpData, lead);
            end else begin
                shifted = cp >> (6 * (len - 1 - i));
                send_item(OpData, {2'b10, shifted[5:0]});
            end
        end
    endtask

    // Hold off the sender until every expected unit is out
    task automatic drain();
        int guard;
        guard = 0;
        i_push <= 1'b0;
        @(posedge i_clk);
        while (waiting != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (10) @(posedge i_clk);
    endtask

    task automatic set_limit(input logic [UnitW-1:0] value);
        drain();
        i_max_units_we <= 1'b1;
        i_max_units    <= value;
        @(posedge i_clk);
        i_max_units_we <= 1'b0;
        settings_used++;
    endtask

    // Result side: random stalls, with calm stretches of steady popping
    initial begin
        int hold;
        int burst;
        i_pop <= 1'b0;
        @(posedge i_clk);
        forever begin
            hold = pop_calm ? 0 : pick_gap();
            if (hold > 0) begin
                i_pop <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            i_pop <= 1'b1;
            burst = $urandom_range(1, 8);
            repeat (burst) @(posedge i_clk);
            if ($urandom_range(0, 29) == 0) begin
                pop_calm = !pop_calm;
            end
        end
    end

    // Item side
    initial begin
        int          target;
        int          chars;
        int          kind;
        int          len;
        logic [20:0] cp;
        i_rst_n        <= 1'b0;
        i_push         <= 1'b0;
        i_operation    <= OpData;
        i_byte_in      <= 8'h00;
        i_max_units_we <= 1'b0;
        i_max_units    <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: ASCII extremes, each sequence length, bad leads,
        // broken sequence, flush at end of string
        send_item(OpData, 8'h00);
        send_item(OpData, 8'h7F);
        send_seq(21'h0000A9, 2, 2);
        send_seq(21'h0020AC, 3, 3);
        send_seq(21'h01F600, 4, 4);
        send_item(OpData, 8'h80);
        send_item(OpData, 8'hFF);
        send_item(OpData, 8'hC3);
        send_item(OpData, 8'h41);
        send_item(OpData, 8'hE4);
        send_item(OpEnd, 8'hFF);

        // Directed: pair with one slot left is dropped, slot reused, then full
        set_limit(7'd2);
        send_item(OpData, 8'h41);
        send_seq(21'h01F600, 4, 4);
        send_item(OpData, 8'h42);
        send_item(OpData, 8'h43);
        send_item(OpEnd, 8'h00);

        // Random strings under each limit setting
        phase_limits[8] = UnitW'($urandom_range(4, 63));
        foreach (phase_limits[p]) begin
            set_limit(phase_limits[p]);
            target = sent + 90;
            while (sent < target) begin
                send_calm = ($urandom_range(0, 4) == 0);
                chars = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 80)
                                                    : $urandom_range(0, 20);
                repeat (chars) begin
                    kind = $urandom_range(0, 99);
                    if (kind < 30) begin
                        send_item(OpData, {1'b0, 7'($urandom_range(0, 127))});
                    end else if (kind < 48) begin
                        // includes overlong two-byte forms
                        send_seq(21'($urandom_range(0, 'h7FF)), 2, 2);
                    end else if (kind < 68) begin
                        // includes surrogate-range values
                        send_seq(21'($urandom_range(0, 'hFFFF)), 3, 3);
                    end else if (kind < 85) begin
                        cp = ($urandom_range(0, 3) == 0) ? 21'($urandom_range(0, 'h1FFFFF))
                                                         : 21'($urandom_range('h10000,
                                                                              'h10FFFF));
                        send_seq(cp, 4, 4);
                    end else if (kind < 93) begin
                        // truncated sequence, broken by whatever follows
                        len = $urandom_range(2, 4);
                        send_seq(21'($urandom), len, $urandom_range(1, len - 1));
                    end else begin
                        send_item(OpData, 8'($urandom));
                    end
                end
                if ($urandom_range(0, 9) != 0) begin
                    send_item(OpEnd, 8'($urandom));
                end
                if ($urandom_range(0, 19) == 0) begin
                    drain();
                end
            end
        end

        send_item(OpEnd, 8'($urandom));
        drain();
        $display("Covered %0d items, %0d units checked, %0d strings closed, %0d limit settings",
                 items, units, strings, settings_used);
        if (waiting != 0) begin
            $display("%0d expected units never arrived", waiting);
        end
        if (fail_count == 0 && waiting == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Guard against a hung handshake
    initial begin
        #14_400_000;
        $display("Timeout with %0d units still expected", waiting);
        $display("Regression FAIL");
        $finish;
    end

endmodule
